/* design/pcef_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcef_pkg: shared types and constants of the paralog column entropy filter
// allele codes, configuration register indexes and the entropy table
// ----------------------------------------------------------------------------
package pcef_pkg;

  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SCORE_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCORE_W-1:0] SCORE_FULL = 17'h10000;

  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_G = 8'h47;
  localparam logic [7:0] ASCII_T = 8'h54;

  typedef enum logic [1:0] {
    ALLELE_A = 2'd0,
    ALLELE_C = 2'd1,
    ALLELE_G = 2'd2,
    ALLELE_T = 2'd3
  } allele_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SCORE       = 2'd0,
    CFG_BASE_POSITION   = 2'd1,
    CFG_PARALOGS_IN_USE = 2'd2,
    CFG_NONE            = 2'd3
  } cfg_idx_e;

  // result of classifying and scoring one column
  typedef struct packed {
    logic                   is_site;
    logic [MAX_LANES-1:0]   valid_lanes;
    logic [SCORE_W-1:0]     score;
  } col_t;

  // (count / total) * log2(total / count) / log2(total), Q0.16
  localparam logic [15:0] ENT_TABLE [9][9] = '{
    '{16'd0, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd32768, 16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd21845, 16'd16125, 16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd16384, 16'd16384, 16'd10200, 16'd0,     16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd13107, 16'd14924, 16'd12480, 16'd7269,  16'd0,    16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd10923, 16'd13394, 16'd12676, 16'd9887,  16'd5557, 16'd0,    16'd0,    16'd0},
    '{16'd0, 16'd9362,  16'd12055, 16'd12230, 16'd10770, 16'd8094, 16'd4450, 16'd0,    16'd0},
    '{16'd0, 16'd8192,  16'd10923, 16'd11592, 16'd10923, 16'd9258, 16'd6800, 16'd3682, 16'd0}
  };

  function automatic logic allele_ok(input logic [7:0] b);
    return (b == ASCII_A) || (b == ASCII_C) || (b == ASCII_G) || (b == ASCII_T);
  endfunction

  function automatic allele_e allele_code(input logic [7:0] b);
    allele_e code;
    case (b)
      ASCII_A: code = ALLELE_A;
      ASCII_C: code = ALLELE_C;
      ASCII_G: code = ALLELE_G;
      default: code = ALLELE_T;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

/* design/pcef_score.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcef_score: column classifier and entropy scorer
// marks valid lanes, detects variation against the reference and sums the
// per-allele entropy table terms with saturation
// ----------------------------------------------------------------------------
module pcef_score #(
  parameter int unsigned PARALOG_LANES = 8
) (
  input  wire logic [7:0]                         ref_base_i,
  input  wire logic [8*pcef_pkg::MAX_LANES-1:0]   paralog_bases_i,
  input  wire logic [pcef_pkg::CNT_W-1:0]         paralogs_in_use_i,
  output pcef_pkg::col_t                          col_o
);

  logic [pcef_pkg::CNT_W-1:0]     lanes_used;
  logic [pcef_pkg::MAX_LANES-1:0] valid;
  logic [pcef_pkg::MAX_LANES-1:0] differs;
  logic [pcef_pkg::CNT_W-1:0]     n_valid;
  logic [pcef_pkg::CNT_W-1:0]     cnt [4];
  logic [2:0]                     distinct;
  logic [17:0]                    sum;
  logic                           ref_ok;

  assign lanes_used = (paralogs_in_use_i > pcef_pkg::CNT_W'(PARALOG_LANES))
                    ? pcef_pkg::CNT_W'(PARALOG_LANES) : paralogs_in_use_i;
  assign ref_ok = pcef_pkg::allele_ok(ref_base_i);

  always_comb begin
    for (int k = 0; k < pcef_pkg::MAX_LANES; k++) begin
      valid[k] = (k < PARALOG_LANES) && (pcef_pkg::CNT_W'(k) < lanes_used) &&
                 pcef_pkg::allele_ok(paralog_bases_i[8*k +: 8]);
      differs[k] = valid[k] && (paralog_bases_i[8*k +: 8] != ref_base_i);
    end
  end

  // per-allele lane counts
  always_comb begin
    n_valid = '0;
    for (int k = 0; k < pcef_pkg::MAX_LANES; k++) begin
      n_valid = n_valid + pcef_pkg::CNT_W'(valid[k]);
    end
    for (int a = 0; a < 4; a++) begin
      cnt[a] = '0;
      for (int k = 0; k < pcef_pkg::MAX_LANES; k++) begin
        if (valid[k] && (pcef_pkg::allele_code(paralog_bases_i[8*k +: 8]) ==
                         pcef_pkg::allele_e'(a))) begin
          cnt[a] = cnt[a] + 4'd1;
        end
      end
    end
  end

  always_comb begin
    distinct = '0;
    sum      = '0;
    for (int a = 0; a < 4; a++) begin
      if (cnt[a] != '0) begin
        distinct = distinct + 3'd1;
        sum      = sum + 18'(pcef_pkg::ENT_TABLE[n_valid][cnt[a]]);
      end
    end
  end

  always_comb begin
    col_o.is_site     = ref_ok && (|differs);
    col_o.valid_lanes = valid;
    if (distinct <= 3'd1) begin
      col_o.score = '0;
    end else if ((4'(distinct) == n_valid) || (sum > 18'(pcef_pkg::SCORE_FULL))) begin
      col_o.score = pcef_pkg::SCORE_FULL;
    end else begin
      col_o.score = sum[pcef_pkg::SCORE_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* design/paralog_column_entropy_filter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// paralog_column_entropy_filter_unit: streaming paralog site filter
// one alignment column per request in (reference base plus up to eight
// paralog bases); a request out for each variant column whose normalized
// entropy score reaches min_score.
// channels: in and out use valid/stall, a request moves when valid is high
// and stall is low. configuration uses valid/ready with a register index;
// ready is always high. writes are to be made only while the unit is idle;
// the unit does not enforce it. a request is taken into the input register,
// scored, then loaded into the result register once that is free.
// throughput: one column per cycle while the output is not stalled, set by
// the single combinational scoring pass between the two registers.
// columns that are not emitted take no output slot.
// reset: clears both pipeline valids, column and site counters, sets
// min_score and base_position to 0 and paralogs_in_use to 8.
// stall: a stalled output holds its result; the input register keeps taking
// requests until it is full behind the result, then in_stall_o rises.
// ----------------------------------------------------------------------------
module paralog_column_entropy_filter_unit #(
  parameter int unsigned PARALOG_LANES = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pcef_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [63:0]                        cfg_data_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               first_column_i,
  input  wire logic [7:0]                         ref_base_i,
  input  wire logic [63:0]                        paralog_bases_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [63:0]                             site_number_o,
  output logic [63:0]                             site_position_o,
  output logic [7:0]                              ref_base_out_o,
  output logic [63:0]                             paralog_bases_out_o,
  output logic [7:0]                              valid_lanes_o,
  output logic [pcef_pkg::SCORE_W-1:0]            score_o
);

  // configuration
  logic [pcef_pkg::SCORE_W-1:0] min_score_q;
  logic [63:0]                  base_position_q;
  logic [pcef_pkg::CNT_W-1:0]   paralogs_in_use_q;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_first_q;
  logic [7:0]  s1_ref_q;
  logic [63:0] s1_lanes_q;

  // counters
  logic [63:0] column_index_q, column_index_d;
  logic [63:0] site_count_q, site_count_d;

  // result register
  logic        s2_valid_q, s2_valid_d;

  logic           s2_free;
  logic           advance;
  logic           in_accept;
  logic           emit;
  logic [63:0]    col_base;
  logic [63:0]    site_base;
  pcef_pkg::col_t col;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q       <= '0;
      base_position_q   <= '0;
      paralogs_in_use_q <= 4'd8;
    end else if (cfg_valid_i) begin
      case (pcef_pkg::cfg_idx_e'(cfg_index_i))
        pcef_pkg::CFG_MIN_SCORE:       min_score_q       <= cfg_data_i[pcef_pkg::SCORE_W-1:0];
        pcef_pkg::CFG_BASE_POSITION:   base_position_q   <= cfg_data_i;
        pcef_pkg::CFG_PARALOGS_IN_USE: paralogs_in_use_q <= cfg_data_i[pcef_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  pcef_score #(
    .PARALOG_LANES(PARALOG_LANES)
  ) u_score (
    .ref_base_i       (s1_ref_q),
    .paralog_bases_i  (s1_lanes_q),
    .paralogs_in_use_i(paralogs_in_use_q),
    .col_o            (col)
  );

  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign col_base  = s1_first_q ? '0 : column_index_q;
  assign site_base = s1_first_q ? '0 : site_count_q;
  assign emit      = col.is_site && (col.score >= min_score_q);

  always_comb begin
    s1_valid_d     = in_accept ? 1'b1 : (s1_valid_q && !advance);
    column_index_d = column_index_q;
    site_count_d   = site_count_q;
    s2_valid_d     = s2_free ? 1'b0 : s2_valid_q;
    if (advance) begin
      column_index_d = col_base + 64'd1;
      site_count_d   = col.is_site ? site_base + 64'd1 : site_base;
      s2_valid_d     = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      column_index_q <= '0;
      site_count_q   <= '0;
    end else begin
      s1_valid_q     <= s1_valid_d;
      s2_valid_q     <= s2_valid_d;
      column_index_q <= column_index_d;
      site_count_q   <= site_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_first_q <= first_column_i;
      s1_ref_q   <= ref_base_i;
      s1_lanes_q <= paralog_bases_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      site_number_o       <= site_base;
      site_position_o     <= base_position_q + col_base;
      ref_base_out_o      <= s1_ref_q;
      paralog_bases_out_o <= s1_lanes_q;
      valid_lanes_o       <= col.valid_lanes;
      score_o             <= col.score;
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule
`default_nettype wire
